>>> rtl/stp_pkg.sv
// stp_pkg: shared types, codes and character constants of the string-to-integer parser
// used by every module under rtl except stp_queue; depends on nothing
`timescale 1ns / 1ps

package stp_pkg;

  // accumulator width default and queue depth
  localparam int WORD_BITS_DEF = 64;
  localparam int QUEUE_DEPTH   = 4;

  // configuration register indexes
  localparam logic [7:0] CFG_RADIX  = 8'd0;
  localparam logic [7:0] CFG_SIGNED = 8'd1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_LOWF  = 8'h66;
  localparam logic [7:0] CH_LOWX  = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // base values
  localparam logic [4:0] BASE_8  = 5'd8;
  localparam logic [4:0] BASE_10 = 5'd10;
  localparam logic [4:0] BASE_16 = 5'd16;

  // one classified character as it travels through the queue
  typedef struct packed {
    logic       last;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       dvalid;
    logic [3:0] dval;
  } stp_item_t;

  // end-of-string snapshot handed from the parser to the result stage
  typedef struct packed {
    logic [15:0] count;
    logic        ovf;
    logic        neg;
    logic        sgn;
  } stp_fin_t;

endpackage

>>> rtl/string_to_integer_parser_top.sv
// string_to_integer_parser_top: streaming numeral parser, configuration registers
// instantiates stp_front, stp_queue, stp_back and stp_emit; depends on stp_pkg
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------------------
//  in_      | slave     | in_tvalid/tready  | tdata char_code[7:0], tlast last
//  out_     | master    | out_tvalid/tready | tdata value[63:0] consumed[79:64],
//           |           |                   | tuser status[1:0]
//  cfg_     | slave     | cfg_valid/ready   | cfg_index 0 radix, 1 signed_mode; cfg_data
//
// one character per cycle is sustained while the queue has room; the digit step (accumulator
// times base plus digit, with overflow taken from the widened product) is combinational in the parser.
// a string's result passes the queue, the snapshot register and the output register before out_tvalid rises.
// reset is synchronous and active low; it clears the queue, parser and output stage.
// a stalled result holds in the output register; the snapshot register and the
// four-entry queue keep characters flowing until both are full.
`timescale 1ns / 1ps

module string_to_integer_parser_top #(
  parameter int WORD_BITS = stp_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input characters
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic        in_tlast,
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // value[63:0], consumed[79:64]
  output logic [1:0]  out_tuser,  // status[1:0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int IW = $bits(stp_pkg::stp_item_t);

  logic               radix_r;
  logic [4:0]         radix_val_r;
  logic               signed_r;

  logic               q_full;
  logic               q_push;
  stp_pkg::stp_item_t push_item;
  logic               q_pop;
  logic               q_valid;
  logic [IW-1:0]      pop_bits;
  stp_pkg::stp_item_t pop_item;

  logic                 fin_ready;
  logic                 fin_load;
  logic [WORD_BITS-1:0] fin_acc;
  stp_pkg::stp_fin_t    fin_info;

  // configuration registers, a write is taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_val_r <= 5'd0;
      signed_r    <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == stp_pkg::CFG_RADIX) begin
        radix_val_r <= cfg_data[4:0];
      end else if (cfg_index == stp_pkg::CFG_SIGNED) begin
        signed_r <= cfg_data[0];
      end
    end
  end

  // marks that a radix write has been seen since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= 1'b0;
    end else if (cfg_valid && cfg_index == stp_pkg::CFG_RADIX) begin
      radix_r <= 1'b1;
    end
  end

  // front: classification
  stp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // queue between front and parser
  stp_queue #(
    .WIDTH (IW),
    .DEPTH (stp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_bits)
  );

  assign pop_item = pop_bits;

  // parser
  stp_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .radix       (radix_r ? radix_val_r : 5'd0),
    .signed_mode (signed_r),
    .q_valid     (q_valid),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .fin_ready   (fin_ready),
    .fin_load    (fin_load),
    .fin_acc     (fin_acc),
    .fin_info    (fin_info)
  );

  // result stage
  stp_emit #(
    .WORD_BITS (WORD_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .fin_load   (fin_load),
    .fin_acc    (fin_acc),
    .fin_info   (fin_info),
    .fin_ready  (fin_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/stp_front.sv
// stp_front: input side, classifies each character and pushes it into the queue
// depends on stp_pkg
`timescale 1ns / 1ps

module stp_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_full,
  output logic              q_push,
  output stp_pkg::stp_item_t q_item
);

  logic [7:0] lower;
  logic       is_dec;
  logic       is_hex;

  // fold upper-case letters to lower case
  assign lower = (in_tdata >= stp_pkg::CH_UPA && in_tdata <= stp_pkg::CH_UPZ) ?
                 (in_tdata | 8'h20) : in_tdata;

  assign is_dec = (in_tdata >= stp_pkg::CH_ZERO) && (in_tdata <= stp_pkg::CH_NINE);
  assign is_hex = (lower >= stp_pkg::CH_LOWA) && (lower <= stp_pkg::CH_LOWF);

  // classification of the character
  always_comb begin
    q_item.last     = in_tlast;
    q_item.is_minus = (in_tdata == stp_pkg::CH_MINUS);
    q_item.is_plus  = (in_tdata == stp_pkg::CH_PLUS);
    q_item.is_zero  = (in_tdata == stp_pkg::CH_ZERO);
    q_item.is_x     = (lower == stp_pkg::CH_LOWX);
    q_item.dvalid   = is_dec | is_hex;
    if (is_dec) begin
      q_item.dval = in_tdata[3:0];
    end else if (is_hex) begin
      q_item.dval = lower[3:0] + 4'd9;
    end else begin
      q_item.dval = 4'd0;
    end
  end

  // a transfer is taken whenever the queue has room
  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

endmodule

>>> rtl/stp_queue.sv
// stp_queue: small register queue between the front and the parser
// generic width and depth; no package dependency
`timescale 1ns / 1ps

module stp_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/stp_back.sv
// stp_back: parser proper, sign/prefix sequencing and digit accumulation
// depends on stp_pkg; feeds the end-of-string snapshot to stp_emit
`timescale 1ns / 1ps

module stp_back #(
  parameter int WORD_BITS = stp_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [4:0]            radix,
  input  logic                  signed_mode,
  input  logic                  q_valid,
  input  stp_pkg::stp_item_t    q_item,
  output logic                  q_pop,
  input  logic                  fin_ready,
  output logic                  fin_load,
  output logic [WORD_BITS-1:0]  fin_acc,
  output stp_pkg::stp_fin_t     fin_info
);

  localparam int PW = WORD_BITS + 6;

  // parse phases
  localparam logic [2:0] PH_START  = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_FIRST  = 3'd2;
  localparam logic [2:0] PH_ZAUTO  = 3'd3;
  localparam logic [2:0] PH_ZXAUTO = 3'd4;
  localparam logic [2:0] PH_ZHEX   = 3'd5;
  localparam logic [2:0] PH_DIGITS = 3'd6;

  logic [2:0]           phase_r, phase_nxt;
  logic [4:0]           base_r, base_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [15:0]          count_r, count_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 neg_r, neg_nxt;
  logic                 stop_r, stop_nxt;

  logic                 take;
  logic                 stop_set;
  logic [1:0]           pre;
  logic                 digit_ok;
  logic                 fin_inc;
  logic [1:0]           inc;
  logic [PW-1:0]        prod;
  logic [16:0]          sum;

  // a string end waits until the snapshot register is free
  assign q_pop    = q_valid & (~q_item.last | fin_ready);
  assign fin_load = q_pop & q_item.last;

  // phase sequencing for one character
  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    neg_nxt   = neg_r;
    take      = 1'b0;
    stop_set  = 1'b0;
    pre       = 2'd0;
    if (!stop_r) begin
      if (phase_r == PH_START && signed_mode && q_item.is_minus) begin
        neg_nxt   = 1'b1;
        phase_nxt = PH_SIGNED;
      end else if ((phase_r == PH_START || phase_r == PH_SIGNED) && q_item.is_plus) begin
        pre       = 2'd1;
        phase_nxt = PH_FIRST;
      end else if (phase_r == PH_START || phase_r == PH_SIGNED || phase_r == PH_FIRST) begin
        // first character after sign: settle the base
        phase_nxt = PH_DIGITS;
        if (radix == 5'd0) begin
          if (q_item.is_zero) begin
            phase_nxt = PH_ZAUTO;
          end else begin
            base_nxt = stp_pkg::BASE_10;
            take     = 1'b1;
          end
        end else begin
          base_nxt = radix;
          if (radix == stp_pkg::BASE_16 && q_item.is_zero) begin
            phase_nxt = PH_ZHEX;
          end else begin
            take = 1'b1;
          end
        end
      end else begin
        case (phase_r)
          PH_ZAUTO: begin
            if (q_item.is_x) begin
              phase_nxt = PH_ZXAUTO;
            end else begin
              // leading zero means octal
              phase_nxt = PH_DIGITS;
              base_nxt  = stp_pkg::BASE_8;
              pre       = 2'd1;
              take      = 1'b1;
            end
          end
          PH_ZXAUTO: begin
            phase_nxt = PH_DIGITS;
            if (q_item.dvalid) begin
              base_nxt = stp_pkg::BASE_16;
              pre      = 2'd2;
              take     = 1'b1;
            end else begin
              // bare 0x: the zero alone is the number
              base_nxt = stp_pkg::BASE_8;
              pre      = 2'd1;
              stop_set = 1'b1;
            end
          end
          PH_ZHEX: begin
            phase_nxt = PH_DIGITS;
            if (q_item.is_x) begin
              pre = 2'd2;
            end else begin
              pre  = 2'd1;
              take = 1'b1;
            end
          end
          default: begin
            take = 1'b1;
          end
        endcase
      end
    end
  end

  // digit accumulation with exact overflow detection on the widened product
  assign prod     = PW'(acc_r) * PW'(base_nxt) + PW'(q_item.dval);
  assign digit_ok = take & q_item.dvalid & ({1'b0, q_item.dval} < base_nxt);

  always_comb begin
    acc_nxt  = digit_ok ? prod[WORD_BITS-1:0] : acc_r;
    ovf_nxt  = ovf_r | (digit_ok & (|prod[PW-1:WORD_BITS]));
    stop_nxt = stop_r | stop_set | (take & ~digit_ok);
    // a zero still under examination at string end counts as a digit
    fin_inc  = q_item.last & ~stop_nxt &
               (phase_nxt == PH_ZAUTO || phase_nxt == PH_ZXAUTO || phase_nxt == PH_ZHEX);
    inc       = pre + 2'(digit_ok) + 2'(fin_inc);
    sum       = {1'b0, count_r} + 17'(inc);
    count_nxt = sum[16] ? 16'hFFFF : sum[15:0];
  end

  // snapshot for the result stage
  assign fin_acc       = acc_nxt;
  assign fin_info.count = count_nxt;
  assign fin_info.ovf   = ovf_nxt;
  assign fin_info.neg   = neg_nxt;
  assign fin_info.sgn   = signed_mode;

  // parser state, back to start after each string
  always_ff @(posedge clk) begin
    if (!rst_n || fin_load) begin
      phase_r <= PH_START;
      base_r  <= 5'd0;
      acc_r   <= '0;
      count_r <= 16'd0;
      ovf_r   <= 1'b0;
      neg_r   <= 1'b0;
      stop_r  <= 1'b0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      neg_r   <= neg_nxt;
      stop_r  <= stop_nxt;
    end
  end

endmodule

>>> rtl/stp_emit.sv
// stp_emit: snapshot register, range check and sign handling, output register
// depends on stp_pkg; drives the result channel
`timescale 1ns / 1ps

module stp_emit #(
  parameter int WORD_BITS = stp_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fin_load,
  input  logic [WORD_BITS-1:0] fin_acc,
  input  stp_pkg::stp_fin_t    fin_info,
  output logic                 fin_ready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [79:0]          out_tdata,
  output logic [1:0]           out_tuser
);

  logic                 fin_valid_r;
  logic [WORD_BITS-1:0] acc_r;
  stp_pkg::stp_fin_t    info_r;
  logic                 fin_move;

  logic                 out_valid_r;
  logic [63:0]          value_r, value_nxt;
  logic [15:0]          used_r, used_nxt;
  logic [1:0]           status_r, status_nxt;

  logic [WORD_BITS-1:0] word_val;
  logic                 above_half;
  logic                 at_least_half;

  assign fin_move  = fin_valid_r & (~out_valid_r | out_tready);
  assign fin_ready = ~fin_valid_r | fin_move;

  // snapshot register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_load) begin
      fin_valid_r <= 1'b1;
    end else if (fin_move) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      acc_r  <= fin_acc;
      info_r <= fin_info;
    end
  end

  // range check against half the word
  assign at_least_half = acc_r[WORD_BITS-1];
  assign above_half    = acc_r[WORD_BITS-1] & (|acc_r[WORD_BITS-2:0]);

  always_comb begin
    word_val   = '0;
    used_nxt   = info_r.count;
    if (info_r.neg && info_r.count != 16'hFFFF) begin
      used_nxt = info_r.count + 16'd1;
    end
    if (info_r.ovf) begin
      status_nxt = stp_pkg::ST_RANGE;
    end else if (info_r.count == 16'd0) begin
      status_nxt = stp_pkg::ST_INVAL;
      used_nxt   = 16'd0;
    end else if (info_r.sgn && info_r.neg) begin
      if (above_half) begin
        status_nxt = stp_pkg::ST_RANGE;
      end else begin
        status_nxt = stp_pkg::ST_OK;
        word_val   = '0 - acc_r;
      end
    end else if (info_r.sgn) begin
      if (at_least_half) begin
        status_nxt = stp_pkg::ST_RANGE;
      end else begin
        status_nxt = stp_pkg::ST_OK;
        word_val   = acc_r;
      end
    end else begin
      status_nxt = stp_pkg::ST_OK;
      word_val   = acc_r;
    end
    // sign extension of a negative signed result
    value_nxt = 64'(word_val);
    if (status_nxt == stp_pkg::ST_OK && info_r.sgn && word_val[WORD_BITS-1]) begin
      value_nxt = value_nxt | ~(64'({WORD_BITS{1'b1}}));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      value_r  <= value_nxt;
      used_r   <= used_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {used_r, value_r};
  assign out_tuser  = status_r;

endmodule

>>> tb/sv/string_to_integer_parser_checker.sv
// string_to_integer_parser_checker: watches the character, result and register channels,
// predicts each parsed number and compares it with the result transfer
// depends on stp_pkg for status codes, register indexes and character constants
`timescale 1ns / 1ps

module string_to_integer_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          pending
);
  import stp_pkg::*;

  typedef enum logic [2:0] {
    P_START, P_SIGN, P_FIRST, P_ZERO_AUTO, P_ZERO_X_AUTO, P_ZERO_HEX, P_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] consumed;
    logic [1:0]  status;
  } number_t;

  // predictor works at the default 64-bit word
  localparam logic [63:0] HALF_RANGE   = 64'h8000_0000_0000_0000;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [7:0]  NOT_A_DIGIT  = 8'hFF;
  localparam int          REPORT_LIMIT = 10;

  logic [4:0]  radix_reg;
  logic        signed_reg;
  scan_phase_t scan;
  logic [4:0]  base_sel;
  logic [63:0] acc;
  logic [15:0] taken;
  logic        wrapped;
  logic        minus_seen;
  logic        halted;
  number_t     number_q[$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CH_UPA && c <= CH_UPZ) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [7:0] digit_of_char(input logic [7:0] c);
    logic [7:0] l;
    l = fold_case(c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (l >= CH_LOWA && l <= CH_LOWF) return l - CH_LOWA + 8'd10;
    return NOT_A_DIGIT;
  endfunction

  function automatic void clear_scan();
    scan       = P_START;
    base_sel   = '0;
    acc        = '0;
    taken      = '0;
    wrapped    = 1'b0;
    minus_seen = 1'b0;
    halted     = 1'b0;
  endfunction

  function automatic void bump_taken();
    if (taken != COUNT_MAX) taken = taken + 16'd1;
  endfunction

  // one digit step with exact overflow from the widened product
  function automatic void accumulate(input logic [7:0] c);
    logic [7:0]  d;
    logic [68:0] wide;
    if (halted) return;
    d = digit_of_char(c);
    if (base_sel == 5'd0 || d >= {3'b000, base_sel}) begin
      halted = 1'b1;
      return;
    end
    wide = {5'b0, acc} * {64'b0, base_sel} + {61'b0, d};
    if (wide[68:64] != 5'd0) wrapped = 1'b1;
    acc = wide[63:0];
    bump_taken();
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    if (halted) return;
    // optional minus, signed mode only
    if (scan == P_START) begin
      scan = P_SIGN;
      if (signed_reg && c == CH_MINUS) begin
        minus_seen = 1'b1;
        return;
      end
    end
    // optional plus
    if (scan == P_SIGN) begin
      scan = P_FIRST;
      if (c == CH_PLUS) begin
        bump_taken();
        return;
      end
    end
    // first character after the signs settles the base
    if (scan == P_FIRST) begin
      scan = P_DIGITS;
      if (radix_reg == 5'd0) begin
        if (c == CH_ZERO) begin
          scan = P_ZERO_AUTO;
          return;
        end
        base_sel = BASE_10;
      end else begin
        base_sel = radix_reg;
        if (radix_reg == BASE_16 && c == CH_ZERO) begin
          scan = P_ZERO_HEX;
          return;
        end
      end
      accumulate(c);
      return;
    end
    case (scan)
      // leading zero under detection: x may open a hex prefix
      P_ZERO_AUTO: begin
        if (fold_case(c) == CH_LOWX) begin
          scan = P_ZERO_X_AUTO;
        end else begin
          scan     = P_DIGITS;
          base_sel = BASE_8;
          accumulate(CH_ZERO);
          accumulate(c);
        end
      end
      // hex only if a hex digit follows, else the zero stands alone in octal
      P_ZERO_X_AUTO: begin
        scan = P_DIGITS;
        if (digit_of_char(c) < 8'd16) begin
          base_sel = BASE_16;
          bump_taken();
          bump_taken();
          accumulate(c);
        end else begin
          base_sel = BASE_8;
          accumulate(CH_ZERO);
          halted = 1'b1;
        end
      end
      // explicit base 16 skips a prefix
      P_ZERO_HEX: begin
        scan = P_DIGITS;
        if (fold_case(c) == CH_LOWX) begin
          bump_taken();
          bump_taken();
        end else begin
          accumulate(CH_ZERO);
          accumulate(c);
        end
      end
      default: accumulate(c);
    endcase
  endfunction

  // end of string: resolve any pending zero, then range and sign
  function automatic number_t close_string();
    number_t r;
    if (!halted && (scan == P_ZERO_AUTO || scan == P_ZERO_X_AUTO)) begin
      base_sel = BASE_8;
      accumulate(CH_ZERO);
    end else if (!halted && scan == P_ZERO_HEX) begin
      accumulate(CH_ZERO);
    end
    r.value    = '0;
    r.consumed = (minus_seen && taken != COUNT_MAX) ? taken + 16'd1 : taken;
    if (wrapped) begin
      r.status = ST_RANGE;
    end else if (taken == 16'd0) begin
      r.status   = ST_INVAL;
      r.consumed = '0;
    end else if (signed_reg && minus_seen) begin
      if (acc > HALF_RANGE) begin
        r.status = ST_RANGE;
      end else begin
        r.status = ST_OK;
        r.value  = 64'd0 - acc;
      end
    end else if (signed_reg && acc >= HALF_RANGE) begin
      r.status = ST_RANGE;
    end else begin
      r.status = ST_OK;
      r.value  = acc;
    end
    clear_scan();
    return r;
  endfunction

  function automatic void log_fault(input string msg);
    mismatches = mismatches + 1;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // result check first, then register and character transfers of the same edge
  always @(posedge clk) begin : watch
    number_t got;
    number_t want;
    if (!rst_n) begin
      radix_reg  = '0;
      signed_reg = 1'b0;
      mismatches = 0;
      clear_scan();
      number_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.value    = out_tdata[63:0];
        got.consumed = out_tdata[79:64];
        got.status   = out_tuser;
        if (number_q.size() == 0) begin
          log_fault($sformatf("%0t: result with none pending: value %h consumed %0d status %0d",
                              $time, got.value, got.consumed, got.status));
        end else begin
          want = number_q.pop_front();
          if (got !== want)
            log_fault($sformatf({"%0t: mismatch: expected value %h consumed %0d status %0d,",
                                 " got value %h consumed %0d status %0d"}, $time,
                                want.value, want.consumed, want.status,
                                got.value, got.consumed, got.status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RADIX) radix_reg = cfg_data[4:0];
        else if (cfg_index == CFG_SIGNED) signed_reg = cfg_data[0];
      end
      if (in_tvalid && in_tready) begin
        feed_char(in_tdata);
        if (in_tlast) number_q.push_back(close_string());
      end
    end
    pending = number_q.size();
  end

endmodule

>>> tb/sv/string_to_integer_parser_top_test.sv
// string_to_integer_parser_top_test: clock, reset, character and register stimulus, result
// back-pressure and the verdict; depends on stp_pkg, the parser top and the checker
`timescale 1ns / 1ps

module string_to_integer_parser_top_test;
  import stp_pkg::*;

  localparam logic [7:0]  CFG_SPARE     = 8'd2;
  localparam logic [7:0]  CH_NUL        = 8'h00;
  localparam logic [7:0]  CH_UPX        = 8'h58;
  localparam logic [7:0]  CH_TOP        = 8'hFF;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 80;
  localparam int          RANDOM_ITEMS  = 760;
  localparam int          PHASE_ITEMS   = 80;
  localparam int          PRESETS       = 10;
  localparam realtime     LIMIT_NS      = 2_000_000;
  // register settings of the first random phases, phase 0 in the low bits
  localparam logic [49:0] PRESET_RADIX  = {5'd16, 5'd17, 5'd2, 5'd31, 5'd1,
                                           5'd8, 5'd10, 5'd16, 5'd0, 5'd0};
  localparam logic [9:0]  PRESET_SIGNED = 10'b0101010110;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // char_code[7:0]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // value[63:0], consumed[79:64]
  logic [1:0]  out_tuser;  // status[1:0]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [7:0]  cfg_data;
  int          mismatches;
  int          pending;

  bit          hold_request;
  bit          spare_done;
  int          burst_left;
  int          items_sent;
  logic [7:0]  text_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  string_to_integer_parser_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  string_to_integer_parser_checker parse_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // one character transfer; bursts of random length with random gaps unless steady
  task automatic push_char(input logic [7:0] c, input logic l, input bit steady);
    int gap;
    if (!steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    items_sent = items_sent + 1;
    if (burst_left > 0) burst_left = burst_left - 1;
  endtask

  task automatic send_text(input bit closing, input bit steady);
    foreach (text_q[i]) push_char(text_q[i], closing && i == text_q.size() - 1, steady);
  endtask

  task automatic text_from(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // input idle, every result in, then the parser's own latency
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // both registers, with random upper data bits; now and then the unused index too
  task automatic set_regs(input logic [4:0] r, input logic s);
    logic [2:0] pad_r;
    logic [6:0] pad_s;
    pad_r = 3'($urandom);
    pad_s = 7'($urandom);
    settle();
    cfg_put(CFG_RADIX, {pad_r, r});
    cfg_put(CFG_SIGNED, {pad_s, s});
    if (!spare_done || $urandom_range(0, 7) == 0) begin
      cfg_put(CFG_SPARE, 8'($urandom));
      spare_done = 1'b1;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_case(input logic [4:0] r, input logic s, input string txt);
    set_regs(r, s);
    text_from(txt);
    send_text(1'b1, 1'b0);
  endtask

  // mostly well-formed numerals with random digits, some noise and broken signs
  task automatic build_random(input logic [4:0] r, input logic s);
    logic [4:0] b;
    int         ndig;
    int         top_digit;
    int         v;
    text_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ((s && $urandom_range(0, 2) == 0) || (!s && $urandom_range(0, 15) == 0))
      text_q.push_back(CH_MINUS);
    if ($urandom_range(0, 4) == 0) text_q.push_back(CH_PLUS);
    b = r;
    if (r == 5'd0) begin
      case ($urandom_range(0, 2))
        0: b = BASE_10;
        1: begin
          b = BASE_8;
          text_q.push_back(CH_ZERO);
        end
        default: begin
          b = BASE_16;
          text_q.push_back(CH_ZERO);
          text_q.push_back($urandom_range(0, 1) ? CH_LOWX : CH_UPX);
        end
      endcase
    end else if (r == BASE_16 && $urandom_range(0, 1) == 1) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(0, 1) ? CH_LOWX : CH_UPX);
    end
    ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 8);
    top_digit = (b > BASE_16) ? 15 : int'(b) - 1;
    for (int i = 0; i < ndig; i++) begin
      // auto-detected decimal must not open with a zero
      if (i == 0 && r == 5'd0 && b == BASE_10) v = $urandom_range(1, 9);
      else v = $urandom_range(0, top_digit);
      if (v < 10) text_q.push_back(CH_ZERO + 8'(v));
      else text_q.push_back(($urandom_range(0, 1) ? CH_LOWA : CH_UPA) + 8'(v - 10));
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
    if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // receiver: changing ready patterns, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 150);
      repeat (span) begin
        @(negedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 3) != 0);
            2: out_tready <= ($urandom_range(0, 1) != 0);
            default: out_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int         goal;
    int         phase_start;
    logic [4:0] r;
    logic       s;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: detection, prefixes, signs and range edges
    run_case(5'd0, 1'b0, "123");
    run_case(5'd0, 1'b0, "0x1F");
    run_case(5'd0, 1'b0, "0X7fz");
    run_case(5'd0, 1'b0, "017");
    run_case(5'd0, 1'b0, "0x");
    run_case(5'd0, 1'b0, "0xg");
    run_case(5'd0, 1'b0, "0");
    run_case(5'd0, 1'b0, "+");
    run_case(5'd0, 1'b0, "-5");
    run_case(5'd0, 1'b0, "+-5");
    run_case(5'd0, 1'b1, "-0");
    run_case(5'd0, 1'b1, "-9223372036854775808");
    run_case(5'd0, 1'b1, "-9223372036854775809");
    run_case(5'd0, 1'b1, "9223372036854775807");
    run_case(5'd0, 1'b1, "+9223372036854775808");
    run_case(5'd0, 1'b0, "18446744073709551615");
    run_case(5'd0, 1'b0, "18446744073709551616");
    run_case(BASE_16, 1'b0, "0x");
    run_case(BASE_16, 1'b0, "0XfFfFffffffffffff1");
    run_case(BASE_16, 1'b1, "-0");
    run_case(5'd1, 1'b0, "0001");
    run_case(5'd31, 1'b0, "Fg9");
    run_case(5'd2, 1'b0, "101z99");

    // NUL ends parsing, later characters ignored; a lone NUL is invalid
    set_regs(BASE_10, 1'b0);
    text_from("12");
    text_q.push_back(CH_NUL);
    text_q.push_back(CH_ZERO + 8'd3);
    text_q.push_back(CH_TOP);
    send_text(1'b1, 1'b0);
    text_q.delete();
    text_q.push_back(CH_NUL);
    send_text(1'b1, 1'b0);

    // registers changed in the middle of a string
    set_regs(5'd0, 1'b1);
    text_from("-4");
    send_text(1'b0, 1'b0);
    set_regs(BASE_8, 1'b0);
    text_from("7");
    send_text(1'b1, 1'b0);

    // random phases: preset extremes first, then random settings
    goal = items_sent + RANDOM_ITEMS;
    for (int p = 0; items_sent < goal; p++) begin
      if (p < PRESETS) begin
        r = PRESET_RADIX[p*5 +: 5];
        s = PRESET_SIGNED[p];
      end else begin
        case ($urandom_range(0, 3))
          0: r = 5'd0;
          1: r = BASE_10;
          2: r = BASE_16;
          default: r = 5'($urandom_range(0, 31));
        endcase
        s = 1'($urandom_range(0, 1));
      end
      set_regs(r, s);
      if (p == 1) hold_request = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_random(r, s);
        send_text(1'b1, 1'b0);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("string_to_integer_parser_top_test OK");
    end else begin
      $display("string_to_integer_parser_top_test NOT OK");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #(LIMIT_NS);
    $display("string_to_integer_parser_top_test NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/stp_pkg.sv
rtl/stp_front.sv
rtl/stp_queue.sv
rtl/stp_back.sv
rtl/stp_emit.sv
rtl/string_to_integer_parser_top.sv
tb/sv/string_to_integer_parser_checker.sv
tb/sv/string_to_integer_parser_top_test.sv
